### sv/mvrt_pkg.sv
// mvrt_pkg: shared types, constants and a helper function for the vertex transform
// used by mvrt_front, mvrt_queue, mvrt_back and model_vertex_rotate_transform_top
package mvrt_pkg;

  localparam int unsigned BufferDepth = 4096;
  localparam int unsigned SlotW       = $clog2(BufferDepth);
  localparam int unsigned OutSlotW    = 12;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegRotOrder = 3'd0,
    RegRotXy    = 3'd1,
    RegRotZHead = 3'd2,
    RegPivot    = 3'd3,
    RegUvScale  = 3'd4,
    RegColorsA  = 3'd5,
    RegColorsB  = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OrdZyx  = 2'd0,
    OrdXzy  = 2'd1,
    OrdYzx  = 2'd2,
    OrdNone = 2'd3
  } rot_order_e;

  // kind of rotation stage
  typedef enum logic [1:0] {
    RotX = 2'd0,
    RotY = 2'd1,
    RotZ = 2'd2,
    RotOff = 2'd3
  } rot_kind_e;

  // item after classification by the front part
  typedef struct packed {
    logic signed [16:0] x;   // position minus pivot
    logic signed [16:0] y;
    logic signed [16:0] z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic               head;
    logic [31:0]        color;
    logic [OutSlotW-1:0] slot;
  } front_item_t;

  function automatic logic [15:0] sat16(input logic signed [31:0] v);
    logic [15:0] r;
    if (v > 32'sd32767) r = 16'h7FFF;
    else if (v < -32'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

### sv/mvrt_queue.sv
// mvrt_queue: two-entry queue between front and back parts
// depends on mvrt_pkg
module mvrt_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mvrt_pkg::front_item_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output mvrt_pkg::front_item_t data_o
);
  mvrt_pkg::front_item_t mem_q [mvrt_pkg::QueueDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
endmodule

### sv/mvrt_front.sv
// mvrt_front: accepts vertices, removes pivot, numbers vertices, picks colour and slot
// depends on mvrt_pkg
module mvrt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic signed [15:0]    pos_z_i,
  input  logic [15:0]           tex_u_i,
  input  logic [15:0]           tex_v_i,
  input  logic                  apply_head_i,
  input  logic                  first_of_part_i,
  input  logic [47:0]           pivot_i,
  input  logic [63:0]           colors_a_i,
  input  logic [63:0]           colors_b_i,
  output logic                  q_push_o,
  output mvrt_pkg::front_item_t q_data_o,
  input  logic                  q_full_i
);
  logic [4:0]                   cnt_q, cnt_d, num;
  logic [mvrt_pkg::SlotW-1:0]   slot_q, slot_d;
  logic [2:0]                   face;
  logic                         acc;

  assign full_o   = q_full_i;
  assign acc      = push_i && !q_full_i;
  assign q_push_o = acc;
  assign num      = first_of_part_i ? 5'd0 : cnt_q;
  assign face     = (num[4:2] > 3'd5) ? 3'd5 : num[4:2];

  always_comb begin
    q_data_o.x = 17'(pos_x_i) - 17'($signed(pivot_i[47:32]));
    q_data_o.y = 17'(pos_y_i) - 17'($signed(pivot_i[31:16]));
    q_data_o.z = 17'(pos_z_i) - 17'($signed(pivot_i[15:0]));
    q_data_o.tex_u = tex_u_i;
    q_data_o.tex_v = tex_v_i;
    q_data_o.head  = apply_head_i;
    q_data_o.slot  = mvrt_pkg::OutSlotW'(slot_q);
    unique case (face)
      3'd0:       q_data_o.color = colors_a_i[63:32];
      3'd1:       q_data_o.color = colors_a_i[31:0];
      3'd2, 3'd3: q_data_o.color = colors_b_i[63:32];
      default:    q_data_o.color = colors_b_i[31:0];
    endcase
    cnt_d  = (num == 5'd31) ? num : num + 5'd1;
    slot_d = slot_q + mvrt_pkg::SlotW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; slot_q <= '0;
    end else if (acc) begin
      cnt_q <= cnt_d; slot_q <= slot_d;
    end
  end

  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && first_of_part_i |=> cnt_q == 5'd1) else $error("part restart lost");
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> slot_q == $past(slot_q) + mvrt_pkg::SlotW'(1)) else $error("slot did not advance");
endmodule

### sv/mvrt_back.sv
// mvrt_back: sequential rotation engine, uv mapping and output register
// depends on mvrt_pkg; one shared set of rotation multipliers steps through the rotations
module mvrt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  mvrt_pkg::front_item_t q_data_i,
  output logic                  q_pop_o,
  input  logic [1:0]            rotation_order_i,
  input  logic [63:0]           rot_xy_trig_i,
  input  logic [63:0]           rot_z_head_trig_i,
  input  logic [47:0]           pivot_i,
  input  logic [31:0]           uv_scale_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic signed [15:0]    out_x_o,
  output logic signed [15:0]    out_y_o,
  output logic signed [15:0]    out_z_o,
  output logic signed [15:0]    out_u_o,
  output logic signed [15:0]    out_v_o,
  output logic [31:0]           vertex_color_o,
  output logic [11:0]           buffer_slot_o
);
  // step 0..3 rotation stages, 4 uv multiply, 5 uv finish and result write
  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d, full_q, full_d;
  logic signed [23:0] x_q, y_q, z_q, x_d, y_d, z_d;
  mvrt_pkg::front_item_t it_q;
  mvrt_pkg::rot_kind_e kind;
  logic signed [15:0] c, s;
  logic signed [23:0] a, b, na, nb;
  logic signed [41:0] pa, pb;
  logic signed [38:0] mu_q, mv_q;
  logic signed [15:0] rx_q, ry_q, rz_q, ru_q, rv_q;
  logic [31:0] col_q;
  logic [11:0] slot_q;

  function automatic logic signed [23:0] rnd14(input logic signed [41:0] p);
    logic signed [41:0] t;
    t = p + 42'sd8192;
    return 24'(t >>> 14);
  endfunction

  // uv: floor(((100t-f)*s + 800)/1600); only large positive values saturate
  function automatic logic [15:0] uv_fin(input logic signed [38:0] m);
    logic signed [39:0] n;
    logic [19:0] d;
    logic [39:0] p;
    logic [15:0] r;
    n = 40'(m) + 40'sd800;
    if (n >= 40'sd52427200) begin
      r = 16'h7FFF;
    end else begin
      // floor by 64, then by 25 through a reciprocal, offset by 41*25 to stay positive
      d = 20'((n >>> 6) + 40'sd1025);
      p = 40'(d) * 40'd671089;
      r = p[39:24] - 16'd41;
    end
    return r;
  endfunction

  function automatic logic signed [38:0] uv_mul(input logic [15:0] t, input logic [15:0] sc);
    logic signed [23:0] k;
    k = 24'(t[14:0]) * 24'sd100 - 24'(t[15]);
    return 39'(k) * $signed({23'd0, sc});
  endfunction

  always_comb begin
    kind = mvrt_pkg::RotOff;
    unique case (step_q)
      3'd0: unique case (rotation_order_i)
        mvrt_pkg::OrdZyx: kind = mvrt_pkg::RotZ;
        mvrt_pkg::OrdXzy: kind = mvrt_pkg::RotX;
        mvrt_pkg::OrdYzx: kind = mvrt_pkg::RotY;
        default:          kind = mvrt_pkg::RotOff;
      endcase
      3'd1: unique case (rotation_order_i)
        mvrt_pkg::OrdZyx: kind = mvrt_pkg::RotY;
        mvrt_pkg::OrdXzy: kind = mvrt_pkg::RotZ;
        mvrt_pkg::OrdYzx: kind = mvrt_pkg::RotZ;
        default:          kind = mvrt_pkg::RotOff;
      endcase
      3'd2: unique case (rotation_order_i)
        mvrt_pkg::OrdZyx: kind = mvrt_pkg::RotX;
        mvrt_pkg::OrdXzy: kind = mvrt_pkg::RotY;
        mvrt_pkg::OrdYzx: kind = mvrt_pkg::RotX;
        default:          kind = mvrt_pkg::RotOff;
      endcase
      3'd3: kind = it_q.head ? mvrt_pkg::RotY : mvrt_pkg::RotOff;
      default: kind = mvrt_pkg::RotOff;
    endcase
    c = '0; s = '0; a = x_q; b = z_q;
    unique case (kind)
      mvrt_pkg::RotX: begin
        c = rot_xy_trig_i[63:48]; s = rot_xy_trig_i[47:32]; a = y_q; b = z_q;
      end
      mvrt_pkg::RotY: begin
        if (step_q == 3'd3) begin
          c = rot_z_head_trig_i[31:16]; s = rot_z_head_trig_i[15:0];
        end else begin
          c = rot_xy_trig_i[31:16]; s = rot_xy_trig_i[15:0];
        end
        a = x_q; b = z_q;
      end
      mvrt_pkg::RotZ: begin
        c = rot_z_head_trig_i[63:48]; s = rot_z_head_trig_i[47:32]; a = x_q; b = y_q;
      end
      default: ;
    endcase
    // y-form is the plus form with s negated
    if (kind == mvrt_pkg::RotY) begin
      pa = 42'(c) * 42'(a) - 42'(s) * 42'(b);
      pb = 42'(s) * 42'(a) + 42'(c) * 42'(b);
    end else begin
      pa = 42'(c) * 42'(a) + 42'(s) * 42'(b);
      pb = 42'(c) * 42'(b) - 42'(s) * 42'(a);
    end
    na = rnd14(pa);
    nb = rnd14(pb);
  end

  assign q_pop_o = !busy_q && !q_empty_i;

  always_comb begin
    step_d = step_q; busy_d = busy_q; full_d = full_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    if (full_q && pop_i) full_d = 1'b0;
    if (q_pop_o) begin
      busy_d = 1'b1; step_d = 3'd0;
      x_d = 24'(q_data_i.x); y_d = 24'(q_data_i.y); z_d = 24'(q_data_i.z);
    end else if (busy_q) begin
      if (step_q <= 3'd3) begin
        unique case (kind)
          mvrt_pkg::RotX: begin y_d = na; z_d = nb; end
          mvrt_pkg::RotY: begin x_d = na; z_d = nb; end
          mvrt_pkg::RotZ: begin x_d = na; y_d = nb; end
          default: ;
        endcase
        step_d = step_q + 3'd1;
      end else if (step_q == 3'd4) begin
        step_d = 3'd5;
      end else if (!full_q || pop_i) begin
        busy_d = 1'b0; full_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; busy_q <= 1'b0; full_q <= 1'b0;
    end else begin
      step_q <= step_d; busy_q <= busy_d; full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    if (q_pop_o) it_q <= q_data_i;
    if (busy_q && step_q == 3'd4) begin
      mu_q <= uv_mul(it_q.tex_u, uv_scale_i[31:16]);
      mv_q <= uv_mul(it_q.tex_v, uv_scale_i[15:0]);
    end
    if (busy_q && step_q == 3'd5 && (!full_q || pop_i)) begin
      rx_q <= mvrt_pkg::sat16(32'(x_q) + 32'($signed(pivot_i[47:32])));
      ry_q <= mvrt_pkg::sat16(32'(y_q) + 32'($signed(pivot_i[31:16])));
      rz_q <= mvrt_pkg::sat16(32'(z_q) + 32'($signed(pivot_i[15:0])));
      ru_q <= uv_fin(mu_q);
      rv_q <= uv_fin(mv_q);
      col_q <= it_q.color;
      slot_q <= it_q.slot;
    end
  end

  assign empty_o = !full_q;
  assign out_x_o = rx_q; assign out_y_o = ry_q; assign out_z_o = rz_q;
  assign out_u_o = ru_q; assign out_v_o = rv_q;
  assign vertex_color_o = col_q; assign buffer_slot_o = slot_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !busy_q) else $error("took item while busy");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= 3'd5) else $error("step out of range");
endmodule

### sv/model_vertex_rotate_transform_top.sv
// model_vertex_rotate_transform_top: top level of the vertex rotate transform
// depends on mvrt_pkg, mvrt_front, mvrt_queue, mvrt_back
//
// vertices are pushed in, classified by the front part (pivot removed, face
// colour and buffer slot chosen) and queued two deep; the back part takes one
// vertex at a time and runs it through a shared rotation unit, one axis per
// cycle (three local stages plus the head yaw stage), then a uv multiply step
// and a uv finish step; the result register lets the next vertex start while
// a result waits to be popped. configuration is written through cfg_we_i,
// cfg_idx_i, cfg_data_i; the user must write only while idle (not enforced)
module model_vertex_rotate_transform_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic [15:0]        tex_u_i,
  input  logic [15:0]        tex_v_i,
  input  logic               apply_head_i,
  input  logic               first_of_part_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic signed [15:0] out_u_o,
  output logic signed [15:0] out_v_o,
  output logic [31:0]        vertex_color_o,
  output logic [11:0]        buffer_slot_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i
);
  logic [1:0]  order_q;
  logic [63:0] xy_q, zh_q, ca_q, cb_q;
  logic [47:0] pivot_q;
  logic [31:0] uv_q;
  logic        q_push, q_full, q_pop, q_empty;
  mvrt_pkg::front_item_t q_in, q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= mvrt_pkg::OrdZyx;
      xy_q <= 64'h4000_0000_4000_0000; zh_q <= 64'h4000_0000_4000_0000;
      pivot_q <= '0; uv_q <= '0; ca_q <= '0; cb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mvrt_pkg::RegRotOrder: order_q <= cfg_data_i[1:0];
        mvrt_pkg::RegRotXy:    xy_q <= cfg_data_i;
        mvrt_pkg::RegRotZHead: zh_q <= cfg_data_i;
        mvrt_pkg::RegPivot:    pivot_q <= cfg_data_i[47:0];
        mvrt_pkg::RegUvScale:  uv_q <= cfg_data_i[31:0];
        mvrt_pkg::RegColorsA:  ca_q <= cfg_data_i;
        mvrt_pkg::RegColorsB:  cb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mvrt_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i, .apply_head_i, .first_of_part_i,
    .pivot_i(pivot_q), .colors_a_i(ca_q), .colors_b_i(cb_q),
    .q_push_o(q_push), .q_data_o(q_in), .q_full_i(q_full)
  );

  mvrt_queue u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_out)
  );

  mvrt_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_out), .q_pop_o(q_pop),
    .rotation_order_i(order_q), .rot_xy_trig_i(xy_q), .rot_z_head_trig_i(zh_q),
    .pivot_i(pivot_q), .uv_scale_i(uv_q), .empty_o(empty), .pop_i(pop),
    .out_x_o, .out_y_o, .out_z_o, .out_u_o, .out_v_o, .vertex_color_o, .buffer_slot_o
  );

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("back part popped empty queue");
endmodule

### tb/sv/testbench.sv
// testbench: self-checking bench for model_vertex_rotate_transform_top
// depends on mvrt_pkg and the rtl below the top level; a queued driver and a monitor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [mvrt_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [15:0] px, py, pz, tu, tv;
    logic        head, first;
  } vertex_t;

  typedef struct {
    logic [15:0] x, y, z, u, v;
    logic [31:0] color;
    logic [11:0] slot;
  } emitted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full, empty;
  logic pop = 1'b0;
  logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [15:0] tex_u = '0, tex_v = '0;
  logic apply_head = 1'b0, first_of_part = 1'b0;
  logic signed [15:0] out_x, out_y, out_z, out_u, out_v;
  logic [31:0] vertex_color;
  logic [11:0] buffer_slot;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  model_vertex_rotate_transform_top u_top (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .tex_u_i(tex_u), .tex_v_i(tex_v),
    .apply_head_i(apply_head), .first_of_part_i(first_of_part),
    .empty(empty), .pop(pop),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .out_u_o(out_u), .out_v_o(out_v),
    .vertex_color_o(vertex_color), .buffer_slot_o(buffer_slot),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // shadow copy of the register file and the counters
  logic [1:0]  sh_order = mvrt_pkg::OrdZyx;
  logic [63:0] sh_xy = 64'h4000_0000_4000_0000;
  logic [63:0] sh_zh = 64'h4000_0000_4000_0000;
  logic [47:0] sh_pivot = '0;
  logic [31:0] sh_uv = '0;
  logic [63:0] sh_col_a = '0, sh_col_b = '0;
  logic [4:0]  part_count = '0;
  logic [11:0] slot_count = '0;

  vertex_t  pending_vertices[$];
  emitted_t expected_vertices[$];
  int unsigned mismatches = 0;
  bit idle_on = 1'b1;
  int unsigned push_gap = 0, pop_stall = 0, quiet_cycles = 0;

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // round a q.22 product sum back to q8.8, halves up
  function automatic longint rnd14(longint p);
    return (p + 8192) >>> 14;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // texel to q4.12; far flag pulls back by a hundredth of a texel
  function automatic logic [15:0] tex_scale(logic [15:0] t, logic [15:0] s);
    longint n;
    n = (100 * longint'(t[14:0]) - longint'(t[15])) * longint'(s) + 160800;
    return clip16(n / 1600 - 100);
  endfunction

  task automatic rot_ab(inout longint a, inout longint b, input longint c, input longint s);
    longint na, nb;
    na = rnd14(c * a + s * b);
    nb = rnd14(c * b - s * a);
    a = na;
    b = nb;
  endtask

  task automatic rot_y(inout longint x, inout longint z, input longint c, input longint s);
    longint nx, nz;
    nx = rnd14(c * x - s * z);
    nz = rnd14(s * x + c * z);
    x = nx;
    z = nz;
  endtask

  task automatic transform_vertex(input vertex_t vin);
    longint px, py, pz, x, y, z, cx, sx, cy, sy, cz, sz, ch, sh;
    logic [4:0] num;
    logic [2:0] face;
    emitted_t e;
    px = sx16(sh_pivot[47:32]); py = sx16(sh_pivot[31:16]); pz = sx16(sh_pivot[15:0]);
    cx = sx16(sh_xy[63:48]); sx = sx16(sh_xy[47:32]);
    cy = sx16(sh_xy[31:16]); sy = sx16(sh_xy[15:0]);
    cz = sx16(sh_zh[63:48]); sz = sx16(sh_zh[47:32]);
    ch = sx16(sh_zh[31:16]); sh = sx16(sh_zh[15:0]);
    x = sx16(vin.px) - px;
    y = sx16(vin.py) - py;
    z = sx16(vin.pz) - pz;
    case (mvrt_pkg::rot_order_e'(sh_order))
      mvrt_pkg::OrdZyx: begin
        rot_ab(x, y, cz, sz); rot_y(x, z, cy, sy); rot_ab(y, z, cx, sx);
      end
      mvrt_pkg::OrdXzy: begin
        rot_ab(y, z, cx, sx); rot_ab(x, y, cz, sz); rot_y(x, z, cy, sy);
      end
      mvrt_pkg::OrdYzx: begin
        rot_y(x, z, cy, sy); rot_ab(x, y, cz, sz); rot_ab(y, z, cx, sx);
      end
      default: ;
    endcase
    if (vin.head) rot_y(x, z, ch, sh);
    // a new part restarts the vertex numbering
    num = vin.first ? 5'd0 : part_count;
    face = (num >> 2) > 5 ? 3'd5 : 3'(num >> 2);
    case (face)
      3'd0: e.color = sh_col_a[63:32];
      3'd1: e.color = sh_col_a[31:0];
      3'd2, 3'd3: e.color = sh_col_b[63:32];
      default: e.color = sh_col_b[31:0];
    endcase
    e.x = clip16(x + px);
    e.y = clip16(y + py);
    e.z = clip16(z + pz);
    e.u = tex_scale(vin.tu, sh_uv[31:16]);
    e.v = tex_scale(vin.tv, sh_uv[15:0]);
    e.slot = slot_count;
    expected_vertices.push_back(e);
    // numbering sticks at 31 on long parts
    part_count = (num < 31) ? num + 5'd1 : num;
    slot_count = 12'((slot_count + 1) % mvrt_pkg::BufferDepth);
  endtask

  // driver: one vertex per transaction, random gap after each while idle_on is set
  vertex_t cur;
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) transform_vertex(cur);
      if (!push || !full) begin
        if (push_gap != 0) begin
          push_gap <= push_gap - 1;
          push <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          cur = pending_vertices.pop_front();
          pos_x <= cur.px; pos_y <= cur.py; pos_z <= cur.pz;
          tex_u <= cur.tu; tex_v <= cur.tv;
          apply_head <= cur.head; first_of_part <= cur.first;
          push <= 1'b1;
          push_gap <= idle_on ? $urandom_range(0, 11) : 0;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: pops with random stalls and checks against the oldest expectation
  emitted_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) $display("unexpected vertex slot %0d", buffer_slot);
        end else begin
          want = expected_vertices.pop_front();
          if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
              want.u !== out_u || want.v !== out_v ||
              want.color !== vertex_color || want.slot !== buffer_slot) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch exp x%h y%h z%h u%h v%h c%h s%h got x%h y%h z%h u%h v%h c%h s%h",
                       want.x, want.y, want.z, want.u, want.v, want.color, want.slot,
                       out_x, out_y, out_z, out_u, out_v, vertex_color, buffer_slot);
          end
        end
        pop_stall = idle_on ? $urandom_range(0, 11) : 0;
        pop <= (pop_stall == 0);
      end else if (pop_stall != 0) begin
        pop_stall--;
        pop <= (pop_stall == 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mvrt_pkg::RegRotOrder: sh_order = d[1:0];
      mvrt_pkg::RegRotXy:    sh_xy = d;
      mvrt_pkg::RegRotZHead: sh_zh = d;
      mvrt_pkg::RegPivot:    sh_pivot = d[47:0];
      mvrt_pkg::RegUvScale:  sh_uv = d[31:0];
      mvrt_pkg::RegColorsA:  sh_col_a = d;
      mvrt_pkg::RegColorsB:  sh_col_b = d;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] trig_pair(int mode);
    real a;
    logic [15:0] c, s;
    if (mode == 0) return $urandom;
    if (mode == 1) return {16'h8000, 16'h7FFF};
    a = $urandom_range(0, 359) * 3.14159265358979 / 180.0;
    c = 16'($rtoi($cos(a) * 16384.0));
    s = 16'($rtoi($sin(a) * 16384.0));
    return {c, s};
  endfunction

  task automatic add_vertex(input logic [15:0] px, py, pz, tu, tv, input logic h, f);
    vertex_t v;
    v.px = px; v.py = py; v.pz = pz; v.tu = tu; v.tv = tv; v.head = h; v.first = f;
    pending_vertices.push_back(v);
  endtask

  function automatic logic [15:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // hold off until the block has drained
  task automatic drain();
    do @(posedge clk);
    while (pending_vertices.size() != 0 || expected_vertices.size() != 0 || push);
    repeat (10) @(posedge clk);
  endtask

  int mode;
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: identity trig, zero scale and colours
    add_vertex(16'h7FFF, 16'h8000, 16'h0100, 16'hFFFF, 16'h8000, 1'b1, 1'b1);
    add_vertex(16'h8000, 16'h7FFF, 16'hFF00, 16'h7FFF, 16'h0000, 1'b0, 1'b0);
    drain();

    write_reg(mvrt_pkg::RegRotOrder, mvrt_pkg::OrdZyx);
    write_reg(mvrt_pkg::RegRotXy, {trig_pair(2), trig_pair(2)});
    write_reg(mvrt_pkg::RegRotZHead, {trig_pair(2), trig_pair(2)});
    write_reg(mvrt_pkg::RegPivot, 48'h7FFF_8000_0100);
    write_reg(mvrt_pkg::RegUvScale, 32'hFFFF_FFFF);
    write_reg(mvrt_pkg::RegColorsA, 64'h1111_1111_2222_2222);
    write_reg(mvrt_pkg::RegColorsB, 64'h3333_3333_4444_4444);
    // an index past the last register must leave everything alone
    write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    add_vertex(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1);
    add_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
    add_vertex(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1'b0, 1'b0);
    add_vertex(16'hFFFF, 16'h0001, 16'h8000, 16'h0001, 16'h8001, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++)
      add_vertex(rand_pos(), rand_pos(), rand_pos(), 16'($urandom), 16'($urandom), 1'b1, 1'b0);
    add_vertex(16'h1234, 16'hEDCB, 16'h0FF0, 16'h4000, 16'hC000, 1'b0, 1'b1);
    drain();
    for (int o = mvrt_pkg::OrdXzy; o <= mvrt_pkg::OrdNone; o++) begin
      write_reg(mvrt_pkg::RegRotOrder, 64'(o));
      add_vertex(16'h7FFF, 16'h8000, 16'h4000, 16'h0010, 16'h8010, 1'b1, 1'b0);
      add_vertex(16'h8000, 16'h7FFF, 16'hC000, 16'h0000, 16'h8000, 1'b0, 1'b0);
      drain();
    end

    // random phases over several register settings
    for (int ph = 0; ph < 12; ph++) begin
      idle_on = (ph % 4 != 3);
      mode = ph % 3;
      write_reg(mvrt_pkg::RegRotOrder, 64'(ph % 4));
      write_reg(mvrt_pkg::RegRotXy, {trig_pair(mode), trig_pair($urandom_range(0, 2))});
      write_reg(mvrt_pkg::RegRotZHead, {trig_pair(mode), trig_pair($urandom_range(0, 2))});
      write_reg(mvrt_pkg::RegPivot, ph == 5 ? 64'hFFFF_FFFF_FFFF_FFFF :
                          (mode == 1 ? 64'h0 : {$urandom, $urandom}));
      write_reg(mvrt_pkg::RegUvScale,
                ph == 2 ? 64'h0 : (ph == 7 ? 64'hFFFF_FFFF : 64'($urandom)));
      write_reg(mvrt_pkg::RegColorsA, {$urandom, $urandom});
      write_reg(mvrt_pkg::RegColorsB,
                ph == 9 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      for (int i = 0; i < 137; i++)
        add_vertex(rand_pos(), rand_pos(), rand_pos(), 16'($urandom), 16'($urandom),
                   1'($urandom), $urandom_range(0, 39) == 0);
      drain();
    end

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // a backlog of more than 64 expectations counts as a failure and is cleared
  always @(posedge clk) begin
    if (rst_n && expected_vertices.size() > 64) begin
      mismatches++;
      expected_vertices.delete();
    end
  end

endmodule
